// File: src/tam_pkg.sv
// Shared types and constants for the tremolo amplitude modulator.
// Holds the state and multiplier-select enums, command/status structs and register map.
// No dependencies.
`timescale 1ns / 1ps

package tam_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 24;
    localparam int unsigned FRAC_W      = 16;
    localparam int unsigned STEP_W      = 24;
    localparam int unsigned PHASE_W     = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_BYPASS     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DEPTH      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_VOLUME     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WAVE_MIX   = 3'd4;

    localparam logic [FRAC_W-1:0] ONE_Q15            = 16'd32768;
    localparam logic [STEP_W-1:0] RST_PHASE_STEP     = 24'd178957;
    localparam logic [FRAC_W-1:0] RST_DEPTH          = 16'd16384;
    localparam logic [FRAC_W-1:0] RST_VOLUME         = 16'd16384;
    localparam logic [FRAC_W-1:0] RST_WAVE_MIX       = 16'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_K_MUL,
        ST_SINE,
        ST_MIX_MUL,
        ST_DEP_MUL,
        ST_GAIN_MUL,
        ST_SMP_MUL,
        ST_FINISH
    } tam_state_t;

    typedef enum logic [2:0] {
        MUL_K,
        MUL_MIX,
        MUL_DEP,
        MUL_GAIN,
        MUL_SMP
    } tam_mul_t;

    typedef struct packed {
        logic              bypass;
        logic [STEP_W-1:0] phase_step;
        logic [FRAC_W-1:0] depth;
        logic [FRAC_W-1:0] volume;
        logic [FRAC_W-1:0] wave_mix;
    } tam_cfg_t;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        tam_mul_t mul_sel;
        logic     sine_load;
        logic     out_load;
    } tam_cmd_t;

    typedef struct packed {
        logic bypass;
        logic out_free;
    } tam_status_t;

    function automatic logic [FRAC_W-1:0] sat_q15(input logic [FRAC_W-1:0] v);
        return (v > ONE_Q15) ? ONE_Q15 : v;
    endfunction

endpackage

// File: src/tam_cfg_regs.sv
// Configuration register file of the tremolo amplitude modulator.
// Fraction registers saturate to 1.0 on write. Depends on tam_pkg.
`timescale 1ns / 1ps

module tam_cfg_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [tam_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tam_pkg::CFG_DATA_W-1:0]    cfg_data,
    output tam_pkg::tam_cfg_t                 cfg
);
    import tam_pkg::*;

    logic              bypass_reg;
    logic [STEP_W-1:0] phase_step_reg;
    logic [FRAC_W-1:0] depth_reg;
    logic [FRAC_W-1:0] volume_reg;
    logic [FRAC_W-1:0] wave_mix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg     <= 1'b0;
            phase_step_reg <= RST_PHASE_STEP;
            depth_reg      <= RST_DEPTH;
            volume_reg     <= RST_VOLUME;
            wave_mix_reg   <= RST_WAVE_MIX;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_BYPASS:     bypass_reg     <= cfg_data[0];
                REG_PHASE_STEP: phase_step_reg <= cfg_data[STEP_W-1:0];
                REG_DEPTH:      depth_reg      <= sat_q15(cfg_data[FRAC_W-1:0]);
                REG_VOLUME:     volume_reg     <= sat_q15(cfg_data[FRAC_W-1:0]);
                REG_WAVE_MIX:   wave_mix_reg   <= sat_q15(cfg_data[FRAC_W-1:0]);
                default:        ;
            endcase
        end
    end

    assign cfg.bypass     = bypass_reg;
    assign cfg.phase_step = phase_step_reg;
    assign cfg.depth      = depth_reg;
    assign cfg.volume     = volume_reg;
    assign cfg.wave_mix   = wave_mix_reg;

endmodule

// File: src/tam_controller.sv
// Sequencer of the tremolo amplitude modulator.
// Steps the shared multiplier through one sample's work. Depends on tam_pkg.
`timescale 1ns / 1ps

module tam_controller
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tam_pkg::tam_status_t  status,
    output tam_pkg::tam_cmd_t     cmd
);
    import tam_pkg::*;

    tam_state_t state_reg;
    tam_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.bypass ? ST_FINISH : ST_K_MUL;
                end
            end
            ST_K_MUL:    state_next = ST_SINE;
            ST_SINE:     state_next = ST_MIX_MUL;
            ST_MIX_MUL:  state_next = ST_DEP_MUL;
            ST_DEP_MUL:  state_next = ST_GAIN_MUL;
            ST_GAIN_MUL: state_next = ST_SMP_MUL;
            ST_SMP_MUL:  state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd.load_in   = 1'b0;
        cmd.mul_en    = 1'b0;
        cmd.mul_sel   = MUL_K;
        cmd.sine_load = 1'b0;
        cmd.out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_K_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_K;
            end
            ST_SINE:
            begin
                cmd.sine_load = 1'b1;
            end
            ST_MIX_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_MIX;
            end
            ST_DEP_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DEP;
            end
            ST_GAIN_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GAIN;
            end
            ST_SMP_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_SMP;
            end
            ST_FINISH:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: src/tam_datapath.sv
// Datapath of the tremolo amplitude modulator: LFO phase, quarter-sine ROM,
// shared multiplier with rounding and clamping, output register. Depends on tam_pkg.
`timescale 1ns / 1ps

module tam_datapath
#(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int SAMPLE_WIDTH     = 24
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  tam_pkg::tam_cfg_t         cfg,
    input  tam_pkg::tam_cmd_t         cmd,
    output tam_pkg::tam_status_t      status,
    input  logic [SAMPLE_WIDTH-1:0]   in_sample,
    input  logic                      in_last,
    output logic [SAMPLE_WIDTH-1:0]   out_sample,
    output logic                      out_last,
    output logic                      out_valid,
    input  logic                      out_ready
);
    import tam_pkg::*;

    localparam int AW = (SAMPLE_WIDTH > 31) ? SAMPLE_WIDTH : 31;
    localparam int BW = 33;
    localparam int PW = AW + BW;
    localparam int KW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam logic signed [PW-1:0] MAXV =
        {{(PW - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [PW-1:0] MINV =
        {{(PW - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};
    localparam logic signed [PW-1:0] HALF_Q30 = PW'(64'd536870912);

    function automatic logic [FRAC_W-1:0] sine_entry(input int unsigned i);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] q;
        x    = (64'd1686629713 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
        term = x;
        sum  = signed'(x);
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'd6;
        sum  = sum - signed'(term);
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'd20;
        sum  = sum + signed'(term);
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'd42;
        sum  = sum - signed'(term);
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'd72;
        sum  = sum + signed'(term);
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'd110;
        sum  = sum - signed'(term);
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'd156;
        sum  = sum + signed'(term);
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        q = (sum + 64'sd16384) >>> 15;
        if (q > 64'sd32768)
        begin
            q = 64'sd32768;
        end
        return q[FRAC_W-1:0];
    endfunction

    logic [FRAC_W-1:0] sine_rom [0:SINE_TABLE_DEPTH];

    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++)
    begin : g_rom
        assign sine_rom[g] = sine_entry(g);
    end

    logic [PHASE_W-1:0]             phase_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic                           last_reg;
    logic signed [FRAC_W:0]         sine_reg;
    logic signed [PW-1:0]           prod_reg;
    logic [SAMPLE_WIDTH-1:0]        out_sample_reg;
    logic                           out_last_reg;
    logic                           out_valid_reg;

    logic [KW-1:0]            k_val;
    logic [KW-1:0]            rom_idx;
    logic [FRAC_W-1:0]        rom_data;
    logic signed [32:0]       sq_term;
    logic signed [32:0]       mix_r;
    logic signed [FRAC_W:0]   lfo;
    logic signed [32:0]       dep_r;
    logic signed [FRAC_W:0]   dep_val;
    logic signed [FRAC_W+1:0] mod_raw;
    logic [FRAC_W:0]          mod_val;
    logic signed [AW-1:0]     mul_a;
    logic signed [BW-1:0]     mul_b;
    logic signed [PW-1:0]     prod_next;
    logic signed [PW-1:0]     res_sh;
    logic [SAMPLE_WIDTH-1:0]  res_sat;

    // Quadrant decode: odd quadrants mirror the index, upper half negates
    assign k_val    = prod_reg[30 + KW - 1:30];
    assign rom_idx  = phase_reg[30] ? (KW'(SINE_TABLE_DEPTH) - k_val) : k_val;
    assign rom_data = sine_rom[rom_idx];

    // Sine/square blend, square term folded in after the multiply
    assign sq_term = phase_reg[31] ? -signed'({2'b00, cfg.wave_mix, 15'd0})
                                   :  signed'({2'b00, cfg.wave_mix, 15'd0});
    assign mix_r   = signed'(prod_reg[32:0]) + sq_term + 33'sd16384;
    assign lfo     = signed'(mix_r[31:15]);

    // Modulation factor, clamped to 0..1
    assign dep_r   = signed'(prod_reg[32:0]) + 33'sd16384;
    assign dep_val = signed'(dep_r[31:15]);
    assign mod_raw = 18'sd32768 - (FRAC_W+2)'(dep_val);

    always_comb
    begin
        if (mod_raw < 0)
        begin
            mod_val = '0;
        end
        else if (mod_raw > 18'sd32768)
        begin
            mod_val = 17'd32768;
        end
        else
        begin
            mod_val = mod_raw[FRAC_W:0];
        end
    end

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_K:
            begin
                mul_a = AW'(signed'({1'b0, phase_reg[29:0]}));
                mul_b = BW'(SINE_TABLE_DEPTH);
            end
            MUL_MIX:
            begin
                mul_a = AW'(sine_reg);
                mul_b = BW'(signed'({1'b0, 17'd32768 - {1'b0, cfg.wave_mix}}));
            end
            MUL_DEP:
            begin
                mul_a = AW'(lfo);
                mul_b = BW'(signed'({1'b0, cfg.depth}));
            end
            MUL_GAIN:
            begin
                mul_a = AW'(signed'({1'b0, mod_val}));
                mul_b = BW'(signed'({1'b0, cfg.volume, 1'b0}));
            end
            MUL_SMP:
            begin
                mul_a = AW'(sample_reg);
                mul_b = signed'({1'b0, prod_reg[31:0]});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Round to nearest at 2^-30 and saturate
    assign res_sh = (prod_reg + HALF_Q30) >>> 30;

    always_comb
    begin
        if (res_sh > MAXV)
        begin
            res_sat = MAXV[SAMPLE_WIDTH-1:0];
        end
        else if (res_sh < MINV)
        begin
            res_sat = MINV[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            res_sat = res_sh[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            sample_reg <= signed'(in_sample);
            last_reg   <= in_last;
        end
        if (cmd.sine_load)
        begin
            sine_reg <= phase_reg[31] ? -signed'({1'b0, rom_data})
                                      :  signed'({1'b0, rom_data});
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.out_load)
        begin
            out_sample_reg <= cfg.bypass ? sample_reg : res_sat;
            out_last_reg   <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_load && !cfg.bypass)
            begin
                phase_reg <= phase_reg + PHASE_W'(cfg.phase_step);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.bypass   = cfg.bypass;
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_sample      = out_sample_reg;
    assign out_last        = out_last_reg;
    assign out_valid       = out_valid_reg;

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken result");

    a_phase_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && !cfg.bypass) |=>
            phase_reg == $past(phase_reg + PHASE_W'(cfg.phase_step)))
        else $error("phase did not advance by the step");

    a_bypass_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && cfg.bypass) |=>
            ($stable(phase_reg) && out_sample_reg == $past(sample_reg)))
        else $error("bypass altered phase or sample");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |-> !cmd.mul_en && !cmd.out_load)
        else $error("sample captured while work in flight");

endmodule

// File: src/tremolo_amplitude_modulator_top.sv
// Tremolo amplitude modulator: LFO-driven gain applied to a signed audio stream.
// Usage:
//   Slave stream s_*: one signed sample per transfer in s_tdata, block end mark in s_tlast.
//   Master stream m_*: one modulated sample per input transfer, mark copied to m_tlast.
//   Configuration: cfg_wr_en writes cfg_data to register cfg_index (0 bypass, 1 phase
//   step, 2 depth, 3 volume, 4 wave mix); write only while no sample is in flight.
// Sequence:
//   A modulated sample passes from transfer in to result loaded through an accept
//   step, six steps of the single shared multiplier sequence (index scale, sine blend,
//   depth, gain, sample scaling) with one ROM read step, and one rounding step.
//   A bypassed sample skips the multiplier sequence and goes from accept to the final load.
//   A new sample is taken only after the previous result is loaded into the output register.
//   The output register frees the input side: the next sample is taken while a result
//   waits. If the receiver stalls the block holds the finished result and stops in its
//   last step until the output register drains.
// Reset: configuration registers return to their defaults, LFO phase to zero, output empty.
// Depends on tam_pkg, tam_cfg_regs, tam_controller and tam_datapath.
`timescale 1ns / 1ps

module tremolo_amplitude_modulator_top
#(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int SAMPLE_WIDTH     = 24
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    input  logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]   s_tdata,   // sample_in
    input  logic                                        s_tlast,   // block_end_in
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0]   m_tdata,   // sample_out
    output logic                                        m_tlast,   // block_end_out
    input  logic                                        cfg_wr_en,
    input  logic [tam_pkg::CFG_INDEX_W-1:0]             cfg_index,
    input  logic [tam_pkg::CFG_DATA_W-1:0]              cfg_data
);
    import tam_pkg::*;

    localparam int DW = ((SAMPLE_WIDTH + 7) / 8) * 8;

    tam_cfg_t                cfg;
    tam_cmd_t                cmd;
    tam_status_t             status;
    logic [SAMPLE_WIDTH-1:0] out_sample;

    tam_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tam_controller u_controller
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tam_datapath
    #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .SAMPLE_WIDTH     (SAMPLE_WIDTH)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .status     (status),
        .in_sample  (s_tdata[SAMPLE_WIDTH-1:0]),
        .in_last    (s_tlast),
        .out_sample (out_sample),
        .out_last   (m_tlast),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready)
    );

    assign m_tdata = DW'(out_sample);

endmodule
